// File: src/hms_duration_text_parser_defines.svh
// Assertion helpers for the duration parser RTL
`ifndef HMS_DURATION_TEXT_PARSER_DEFINES_SVH
`define HMS_DURATION_TEXT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define HMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define HMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define HMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/hms_pkg.sv
package hms_pkg;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Field bookkeeping
    localparam logic [1:0] FIELDS_NONE = 2'd0;
    localparam logic [1:0] FIELDS_MS   = 2'd1;
    localparam logic [1:0] FIELDS_HMS  = 2'd2;

    // Scale factors
    localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] SEC_PER_MIN  = 32'd60;

    // One input character transaction
    typedef struct packed {
        logic [7:0] text_char;
        logic       char_present;
        logic       is_last;
    } t_char_item;

    // Split fields of one finished string
    typedef struct packed {
        logic        ok;
        logic [31:0] hours;
        logic [31:0] minutes;
        logic [31:0] seconds;
    } t_hms_fields;

endpackage

// File: src/hms_char_if.sv
interface hms_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       char_present;
    logic       is_last;

    modport source (output valid, output text_char, output char_present,
                    output is_last, input ready);
    modport sink   (input valid, input text_char, input char_present,
                    input is_last, output ready);
endinterface

// File: src/hms_result_if.sv
interface hms_result_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic [31:0] total_seconds;

    modport source (output valid, output parse_ok, output total_seconds, input ready);
    modport sink   (input valid, input parse_ok, input total_seconds, output ready);
endinterface

// File: src/hms_parse.sv
module hms_parse
    import hms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_char_item  i_item,
    output logic        o_take,
    input  logic        i_down_ready,
    output logic        o_valid,
    output t_hms_fields o_fields
);

    logic        r_seen_nonspace, n_seen_nonspace;
    logic        r_space_pending, n_space_pending;
    logic        r_failed,        n_failed;
    logic [1:0]  r_fields_closed, n_fields_closed;
    logic        r_field_nonempty, n_field_nonempty;
    logic [31:0] r_digit_accum,   n_digit_accum;
    logic [31:0] r_first_field,   n_first_field;
    logic [31:0] r_second_field,  n_second_field;

    logic        r_valid;
    t_hms_fields r_fields, n_fields;

    logic        w_is_ws;
    logic        w_is_digit;
    logic [31:0] w_digit;
    logic        w_res_slot;

    // Take a character unless it ends a string and the result slot is full and not draining
    assign w_res_slot = !r_valid || i_down_ready;
    assign o_take     = i_valid && (!i_item.is_last || w_res_slot);

    // Classify the character
    always_comb begin
        w_is_ws    = (i_item.text_char inside {CH_SPACE, [CH_TAB:CH_CR]});
        w_is_digit = (i_item.text_char inside {[CH_ZERO:CH_NINE]});
        w_digit    = {28'd0, i_item.text_char[3:0]};
    end

    // Advance the scan state by one character
    always_comb begin
        n_seen_nonspace  = r_seen_nonspace;
        n_space_pending  = r_space_pending;
        n_failed         = r_failed;
        n_fields_closed  = r_fields_closed;
        n_field_nonempty = r_field_nonempty;
        n_digit_accum    = r_digit_accum;
        n_first_field    = r_first_field;
        n_second_field   = r_second_field;
        if (i_item.char_present) begin
            if (w_is_ws) begin
                if (r_seen_nonspace) begin
                    n_space_pending = 1'b1;
                end
            end else begin
                if (r_space_pending) begin
                    n_failed = 1'b1;
                end
                n_seen_nonspace = 1'b1;
                if (i_item.text_char == CH_COLON) begin
                    if (!r_field_nonempty || r_fields_closed >= FIELDS_HMS) begin
                        n_failed = 1'b1;
                    end else begin
                        if (r_fields_closed == FIELDS_NONE) begin
                            n_first_field = r_digit_accum;
                        end else begin
                            n_second_field = r_digit_accum;
                        end
                        n_fields_closed  = r_fields_closed + 2'd1;
                        n_digit_accum    = '0;
                        n_field_nonempty = 1'b0;
                    end
                end else if (w_is_digit) begin
                    // accum * 10 as two shifts, wrapping at 32 bits
                    n_digit_accum    = (r_digit_accum << 3) + (r_digit_accum << 1) + w_digit;
                    n_field_nonempty = 1'b1;
                end else begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    // Split the finished string into hours, minutes and seconds
    always_comb begin
        n_fields.ok      = !n_failed && n_seen_nonspace && n_field_nonempty;
        n_fields.seconds = n_digit_accum;
        case (n_fields_closed)
            FIELDS_MS: begin
                n_fields.hours   = '0;
                n_fields.minutes = n_first_field;
            end
            FIELDS_HMS: begin
                n_fields.hours   = n_first_field;
                n_fields.minutes = n_second_field;
            end
            default: begin
                n_fields.hours   = '0;
                n_fields.minutes = '0;
            end
        endcase
    end

    // Hold scan state; clear it after the last character of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_nonspace  <= 1'b0;
            r_space_pending  <= 1'b0;
            r_failed         <= 1'b0;
            r_fields_closed  <= FIELDS_NONE;
            r_field_nonempty <= 1'b0;
            r_digit_accum    <= '0;
            r_first_field    <= '0;
            r_second_field   <= '0;
        end else if (o_take) begin
            if (i_item.is_last) begin
                r_seen_nonspace  <= 1'b0;
                r_space_pending  <= 1'b0;
                r_failed         <= 1'b0;
                r_fields_closed  <= FIELDS_NONE;
                r_field_nonempty <= 1'b0;
                r_digit_accum    <= '0;
                r_first_field    <= '0;
                r_second_field   <= '0;
            end else begin
                r_seen_nonspace  <= n_seen_nonspace;
                r_space_pending  <= n_space_pending;
                r_failed         <= n_failed;
                r_fields_closed  <= n_fields_closed;
                r_field_nonempty <= n_field_nonempty;
                r_digit_accum    <= n_digit_accum;
                r_first_field    <= n_first_field;
                r_second_field   <= n_second_field;
            end
        end
    end

    // Result slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take && i_item.is_last) begin
            r_valid <= 1'b1;
        end else if (i_down_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result slot payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_item.is_last) begin
            r_fields <= n_fields;
        end
    end

    assign o_valid  = r_valid;
    assign o_fields = r_fields;

endmodule

// File: src/hms_sum.sv
module hms_sum
    import hms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_hms_fields i_fields,
    output logic        o_ready,
    output logic        o_valid,
    output logic        o_parse_ok,
    output logic [31:0] o_total_seconds,
    input  logic        i_ready
);

    logic        r_prod_valid;
    logic        r_prod_ok;
    logic [31:0] r_hour_sec;
    logic [31:0] r_min_sec;
    logic [31:0] r_sec;

    logic        r_out_valid;
    logic        r_out_ok;
    logic [31:0] r_out_total;

    logic        w_out_load;
    logic        w_prod_load;
    logic [31:0] w_total;

    // Pipeline handshake: each stage loads when empty or draining
    assign w_out_load  = r_prod_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_prod_valid || !r_out_valid || i_ready;
    assign w_prod_load = i_valid && o_ready;

    // Product stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (o_ready) begin
            r_prod_valid <= i_valid;
        end
    end

    // Scale hours and minutes to seconds, wrapping at 32 bits
    always_ff @(posedge i_clk) begin
        if (w_prod_load) begin
            r_prod_ok  <= i_fields.ok;
            r_hour_sec <= i_fields.hours * SEC_PER_HOUR;
            r_min_sec  <= i_fields.minutes * SEC_PER_MIN;
            r_sec      <= i_fields.seconds;
        end
    end

    // Add the parts; force zero on a bad string
    assign w_total = r_prod_ok ? (r_hour_sec + r_min_sec + r_sec) : '0;

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ok    <= r_prod_ok;
            r_out_total <= w_total;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_parse_ok      = r_out_ok;
    assign o_total_seconds = r_out_total;

endmodule

// File: src/hms_duration_text_parser.sv
// Channel    Dir  Payload                               Transaction
// i_char     in   text_char, char_present, is_last      one character of the string
// o_result   out  parse_ok, total_seconds               one result per string
//
// One character per cycle, sustained, with the output never stalled.
// A result passes through these registers on its way to the output, in order:
// input register, scan stage, multiply stage, sum/output register.
// Reset (synchronous, active low) empties all stages and clears the scan state.
// A stalled output backs up the pipeline one stage at a time; characters that do
// not end a string keep flowing into the scan state while a result waits.
`include "hms_duration_text_parser_defines.svh"

module hms_duration_text_parser
    import hms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hms_char_if.sink    i_char,
    hms_result_if.source o_result
);

    logic        r_in_valid;
    t_char_item  r_in_item;

    logic        w_take;
    logic        w_fields_valid;
    t_hms_fields w_fields;
    logic        w_sum_ready;
    logic        w_res_bad;

    // Accept a new character while the input register is empty or draining
    assign i_char.ready = !r_in_valid || w_take;

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_item.text_char    <= i_char.text_char;
            r_in_item.char_present <= i_char.char_present;
            r_in_item.is_last      <= i_char.is_last;
        end
    end

    // Scan the character stream and split the fields
    hms_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_item       (r_in_item),
        .o_take       (w_take),
        .i_down_ready (w_sum_ready),
        .o_valid      (w_fields_valid),
        .o_fields     (w_fields)
    );

    // Scale and add into the result
    hms_sum u_sum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_fields_valid),
        .i_fields        (w_fields),
        .o_ready         (w_sum_ready),
        .o_valid         (o_result.valid),
        .o_parse_ok      (o_result.parse_ok),
        .o_total_seconds (o_result.total_seconds),
        .i_ready         (o_result.ready)
    );

    // Flag a presented result for a bad string
    assign w_res_bad = o_result.valid && !o_result.parse_ok;

    // Checks
    `HMS_ASSERT_NEXT(a_in_load, i_clk, i_rst_n, i_char.valid && i_char.ready, r_in_valid)
    `HMS_ASSERT_IMPL(a_in_free, i_clk, i_rst_n, !r_in_valid, i_char.ready)
    `HMS_ASSERT_IMPL(a_zero_on_fail, i_clk, i_rst_n, w_res_bad, o_result.total_seconds == 32'd0)

endmodule
